// ----- src/ncs_pkg.sv -----
// package for the nearest-cylinder request scheduler
// field widths, operation codes, default sizes and the transfer structs
// no dependencies
`default_nettype none

package ncs_pkg;

	localparam int QUEUE_DEPTH_DEF   = 32;
	localparam int CYLINDER_BITS_DEF = 13;

	localparam int OP_W     = 2;
	localparam int SLOT_W   = 5;
	localparam int CYL_W    = 13;
	localparam int ACTIVE_W = 6;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_HEAD  = 2'd1;
	localparam logic [OP_W-1:0] OP_SERVE = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [SLOT_W-1:0] slot;
		logic [CYL_W-1:0]  cylinder;
	} cmd_t;

	typedef struct packed {
		logic [SLOT_W-1:0] served_slot;
		logic [CYL_W-1:0]  served_cylinder;
		logic [CYL_W-1:0]  seek_distance;
	} result_t;

endpackage

`default_nettype wire

// ----- src/nearest_cylinder_request_scheduler_unit.sv -----
// nearest-cylinder request scheduler, top level
// request table in a synchronous memory, head register, serve sequencer
// depends on ncs_pkg
// a write or set-head command gives no result
// a serve scans the first N table entries, N the active entry count, reading
// one table entry per cycle from the memory port
// the result shows for one cycle with done high; the receiver cannot stall
// reset: head position zero, active count one; table contents stay undefined
`default_nettype none

module nearest_cylinder_request_scheduler_unit #(
	parameter int QUEUE_DEPTH   = ncs_pkg::QUEUE_DEPTH_DEF,
	parameter int CYLINDER_BITS = ncs_pkg::CYLINDER_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire ncs_pkg::cmd_t                 cmd,
	output logic                               done,
	output ncs_pkg::result_t                   result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ncs_pkg::ACTIVE_W-1:0]  cfg_data
);

	localparam int IdxW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int SlotW = ncs_pkg::SLOT_W;
	localparam int OutW  = ncs_pkg::CYL_W;
	localparam int CntW  = 9;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [ncs_pkg::ACTIVE_W-1:0]   active_q;
	logic [CYLINDER_BITS-1:0]       head_q;
	logic [CYLINDER_BITS-1:0]       repl_q;
	logic [IdxW-1:0]                idx_q;
	logic [IdxW-1:0]                last_q;

	logic [CYLINDER_BITS-1:0]       mem [QUEUE_DEPTH];
	logic [CYLINDER_BITS-1:0]       rd_data_s1;
	logic [IdxW-1:0]                rd_idx_s1;
	logic                           rd_vld_s1;
	logic                           first_s1;

	logic [IdxW-1:0]                best_idx_q;
	logic [CYLINDER_BITS-1:0]       best_cyl_q;
	logic [CYLINDER_BITS-1:0]       best_dist_q;

	logic                           done_q;
	ncs_pkg::result_t               result_q;

	logic                           accept;
	logic [CYLINDER_BITS-1:0]       in_cyl;
	logic                           mem_we;
	logic [IdxW-1:0]                mem_wa;
	logic [CYLINDER_BITS-1:0]       mem_wd;
	logic [CYLINDER_BITS-1:0]       seek_d;
	logic [CntW-1:0]                cnt;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign in_cyl    = CYLINDER_BITS'(cmd.cylinder);
	assign done      = done_q;
	assign result    = result_q;

	// effective active count, clamped to 1..QUEUE_DEPTH
	always_comb begin
		cnt = CntW'(active_q);
		if (cnt == '0) begin
			cnt = CntW'(1);
		end
		if (cnt > CntW'(QUEUE_DEPTH)) begin
			cnt = CntW'(QUEUE_DEPTH);
		end
	end

	assign seek_d = (rd_data_s1 >= head_q) ? (rd_data_s1 - head_q) : (head_q - rd_data_s1);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = IdxW'(cmd.slot);
		mem_wd = in_cyl;
		if (state_q == ST_FINISH) begin
			mem_we = 1'b1;
			mem_wa = best_idx_q;
			mem_wd = repl_q;
		end else if (accept && cmd.op == ncs_pkg::OP_WRITE
				&& 32'(cmd.slot) < QUEUE_DEPTH) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[idx_q];
		rd_idx_s1  <= idx_q;
		first_s1   <= (idx_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= ncs_pkg::ACTIVE_W'(1);
			head_q    <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q    <= (state_q == ST_FINISH);
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (cmd.op == ncs_pkg::OP_HEAD) begin
							head_q <= in_cyl;
						end else if (cmd.op == ncs_pkg::OP_SERVE) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (idx_q == last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IdxW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					head_q  <= best_cyl_q;
					idx_q   <= '0;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// serve bookkeeping, nearest-entry compare and result capture
	always_ff @(posedge clk) begin
		if (accept && cmd.op == ncs_pkg::OP_SERVE) begin
			repl_q <= in_cyl;
			last_q <= IdxW'(cnt - CntW'(1));
		end
		if (rd_vld_s1 && (first_s1 || seek_d < best_dist_q)) begin
			best_idx_q  <= rd_idx_s1;
			best_cyl_q  <= rd_data_s1;
			best_dist_q <= seek_d;
		end
		if (state_q == ST_FINISH) begin
			result_q.served_slot     <= SlotW'(best_idx_q);
			result_q.served_cylinder <= OutW'(best_cyl_q);
			result_q.seek_distance   <= OutW'(best_dist_q);
		end
	end

endmodule

`default_nettype wire
